@@ rtl/ifmtr_pkg.sv @@
// ----------------------------------------------------------------------------
// ifmtr_pkg
// Shared types and constants of the IPv4 flow match and TTL rewrite unit.
// ----------------------------------------------------------------------------
package ifmtr_pkg;

	// item action codes
	localparam logic ACT_INSTALL = 1'b0;
	localparam logic ACT_BYTE    = 1'b1;

	// frame layout, offsets relative to the start of the IP header
	localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [15:0] OFS_IHL       = 16'd0;
	localparam logic [15:0] OFS_TTL       = 16'd8;
	localparam logic [15:0] OFS_CSUM_HI   = 16'd10;
	localparam logic [15:0] OFS_CSUM_LO   = 16'd11;
	localparam logic [13:0] OFS_SRC_WORD  = 14'd3;   // bytes 12 to 15
	localparam logic [13:0] OFS_DST_WORD  = 14'd4;   // bytes 16 to 19
	localparam logic [15:0] IP_MIN_BYTES  = 16'd20;
	localparam logic [15:0] LEN_MAX       = 16'hFFFF;
	localparam logic [15:0] TTL_GAP_LEN   = 16'd22;  // frame ends before the ttl byte
	localparam logic [5:0]  TTL_HDR_MIN   = 6'd8;
	localparam logic [16:0] TTL_FILL_WORD = 17'h0FF00;

	localparam int SUM_W       = 21;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// one command from the parser to the table side
	typedef struct packed {
		logic             is_install;
		logic [7:0]       key;
		logic [31:0]      src_addr;
		logic [31:0]      dst_addr;
		logic [SUM_W-1:0] sum;
		logic [16:0]      corr;
		logic [7:0]       new_ttl;
		logic [5:0]       hdr_bytes;
		logic [15:0]      count;
		logic             complete;
	} cmd_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ rtl/ipv4_flow_match_ttl_rewrite_unit.sv @@
// ----------------------------------------------------------------------------
// ipv4_flow_match_ttl_rewrite_unit
// Flow table match of IPv4 frames with TTL decrement and checksum rewrite.
// ----------------------------------------------------------------------------
// channel   handshake                    payload
// item      item_valid / item_ready      action, rule_src_addr, rule_dst_addr,
//                                        frame_byte, frame_last
// result    result_valid / result_ready  forward, new_ttl, new_checksum,
//                                        header_bytes, frame_length
//
// one item is taken every cycle while the four-entry command queue has room
// the result of a frame passes the queue slot, the table read stage and the
// result register after the last byte of the frame is taken
// reset clears the parse state and the table valid bits at once, no sweep
// a stalled result side fills the queue, then item_ready drops
// ----------------------------------------------------------------------------
module ipv4_flow_match_ttl_rewrite_unit import ifmtr_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [31:0] rule_src_addr,
	input  logic [31:0] rule_dst_addr,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        forward,
	output logic [7:0]  new_ttl,
	output logic [15:0] new_checksum,
	output logic [5:0]  header_bytes,
	output logic [15:0] frame_length
);

	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        head_cmd;
	queue_stat_t q_stat;

	// parser
	ifmtr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.action        (action),
		.rule_src_addr (rule_src_addr),
		.rule_dst_addr (rule_dst_addr),
		.frame_byte    (frame_byte),
		.frame_last    (frame_last),
		.q_stat        (q_stat),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// command queue
	ifmtr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	// table side
	ifmtr_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.forward      (forward),
		.new_ttl      (new_ttl),
		.new_checksum (new_checksum),
		.header_bytes (header_bytes),
		.frame_length (frame_length)
	);

endmodule

@@ rtl/ifmtr_front.sv @@
// ----------------------------------------------------------------------------
// ifmtr_front
// Accepts items, parses frame bytes and pushes install and lookup commands.
// ----------------------------------------------------------------------------
module ifmtr_front import ifmtr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [31:0] rule_src_addr,
	input  logic [31:0] rule_dst_addr,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,
	input  queue_stat_t q_stat,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [15:0]      pos_q;
	logic [3:0]       hlw_q;
	logic [7:0]       ttl_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0]       pend_q;
	logic [31:0]      src_q;
	logic [31:0]      dst_q;

	logic             take;
	logic             at_hdr;
	logic [15:0]      off;
	logic [15:0]      cnt;
	logic [3:0]       nxt_hlw;
	logic [7:0]       nxt_ttl;
	logic [SUM_W-1:0] nxt_sum;
	logic [7:0]       nxt_pend;
	logic [31:0]      nxt_src;
	logic [31:0]      nxt_dst;
	logic [7:0]       v;
	logic             in_hdr;
	logic [5:0]       hb;
	logic [15:0]      got;
	logic             add_pend;
	logic             add_ttl;
	logic [16:0]      corr;

	assign item_ready = !q_stat.full;
	assign take       = item_valid && item_ready;

	// per-byte parse update
	always_comb begin
		at_hdr   = (pos_q >= ETH_HDR_BYTES);
		off      = pos_q - ETH_HDR_BYTES;
		cnt      = (pos_q != LEN_MAX) ? pos_q + 16'd1 : LEN_MAX;
		nxt_hlw  = (at_hdr && off == OFS_IHL) ? frame_byte[3:0] : hlw_q;
		nxt_ttl  = (at_hdr && off == OFS_TTL) ? frame_byte : ttl_q;
		v        = frame_byte;
		if (at_hdr && off == OFS_TTL)
			v = frame_byte - 8'd1;
		if (at_hdr && (off == OFS_CSUM_HI || off == OFS_CSUM_LO))
			v = 8'd0;
		nxt_src  = (at_hdr && off[15:2] == OFS_SRC_WORD) ? {src_q[23:0], frame_byte} : src_q;
		nxt_dst  = (at_hdr && off[15:2] == OFS_DST_WORD) ? {dst_q[23:0], frame_byte} : dst_q;
		in_hdr   = at_hdr && (off < {10'd0, nxt_hlw, 2'b00});
		nxt_pend = (in_hdr && !off[0]) ? v : pend_q;
		nxt_sum  = (in_hdr && off[0]) ? sum_q + {5'd0, pend_q, v} : sum_q;
	end

	// end-of-frame summary
	always_comb begin
		hb       = {nxt_hlw, 2'b00};
		got      = cnt - ETH_HDR_BYTES;
		add_pend = (cnt > ETH_HDR_BYTES) && (got < {10'd0, hb}) && got[0];
		add_ttl  = (cnt <= TTL_GAP_LEN) && (hb > TTL_HDR_MIN);
		corr     = (add_pend ? {1'b0, nxt_pend, 8'd0} : 17'd0)
		         + (add_ttl ? TTL_FILL_WORD : 17'd0);
	end

	// command towards the table side
	always_comb begin
		push                = take && (action == ACT_INSTALL || frame_last);
		push_cmd.is_install = (action == ACT_INSTALL);
		push_cmd.key        = (action == ACT_INSTALL) ?
		                      (rule_src_addr[31:24] ^ rule_dst_addr[31:24]) :
		                      (nxt_src[31:24] ^ nxt_dst[31:24]);
		push_cmd.src_addr   = (action == ACT_INSTALL) ? rule_src_addr : nxt_src;
		push_cmd.dst_addr   = (action == ACT_INSTALL) ? rule_dst_addr : nxt_dst;
		push_cmd.sum        = nxt_sum;
		push_cmd.corr       = corr;
		push_cmd.new_ttl    = nxt_ttl - 8'd1;
		push_cmd.hdr_bytes  = hb;
		push_cmd.count      = cnt;
		push_cmd.complete   = (cnt >= ETH_HDR_BYTES + IP_MIN_BYTES) &&
		                      (cnt >= ETH_HDR_BYTES + {10'd0, hb});
	end

	// parse state, cleared after the last byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hlw_q  <= '0;
			ttl_q  <= '0;
			sum_q  <= '0;
			pend_q <= '0;
			src_q  <= '0;
			dst_q  <= '0;
		end else if (take && action == ACT_BYTE) begin
			if (frame_last) begin
				pos_q  <= '0;
				hlw_q  <= '0;
				ttl_q  <= '0;
				sum_q  <= '0;
				pend_q <= '0;
				src_q  <= '0;
				dst_q  <= '0;
			end else begin
				pos_q  <= cnt;
				hlw_q  <= nxt_hlw;
				ttl_q  <= nxt_ttl;
				sum_q  <= nxt_sum;
				pend_q <= nxt_pend;
				src_q  <= nxt_src;
				dst_q  <= nxt_dst;
			end
		end
	end

endmodule

@@ rtl/ifmtr_queue.sv @@
// ----------------------------------------------------------------------------
// ifmtr_queue
// Short command queue between the parser and the table side.
// ----------------------------------------------------------------------------
module ifmtr_queue import ifmtr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cmd_t        push_cmd,
	input  logic        pop,
	output cmd_t        head_cmd,
	output queue_stat_t q_stat
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head_cmd     = slot_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ rtl/ifmtr_back.sv @@
// ----------------------------------------------------------------------------
// ifmtr_back
// Flow table memory, rule writes, lookup and result register.
// ----------------------------------------------------------------------------
module ifmtr_back import ifmtr_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head_cmd,
	input  queue_stat_t q_stat,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        forward,
	output logic [7:0]  new_ttl,
	output logic [15:0] new_checksum,
	output logic [5:0]  header_bytes,
	output logic [15:0] frame_length
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [63:0]        flow_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;

	logic [IDX_W-1:0]   idx;
	logic               wr_en;
	logic               rd_en;
	logic               s1_free;
	logic               s1_adv;

	logic               valid_s1;
	logic [63:0]        rd_data_s1;
	logic               vld_s1;
	logic [31:0]        src_s1;
	logic [31:0]        dst_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [7:0]         ttl_s1;
	logic [5:0]         hb_s1;
	logic [15:0]        cnt_s1;
	logic               cmpl_s1;

	logic [63:0]        entry;
	logic [16:0]        fold1;
	logic [16:0]        fold2;

	// octet key to table index, a constant table folded into logic
	always_comb begin
		idx = '0;
		for (int k = 0; k < 256; k++)
			if (head_cmd.key == 8'(k))
				idx = IDX_W'(k % TABLE_ENTRIES);
	end

	// pop and stage control
	always_comb begin
		s1_adv  = valid_s1 && (!result_valid || result_ready);
		s1_free = !valid_s1 || s1_adv;
		pop     = !q_stat.empty && (head_cmd.is_install || s1_free);
		wr_en   = pop && head_cmd.is_install;
		rd_en   = pop && !head_cmd.is_install;
	end

	// flow table memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			flow_mem[idx] <= {head_cmd.src_addr, head_cmd.dst_addr};
		if (rd_en)
			rd_data_s1 <= flow_mem[idx];
	end

	// entry valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (wr_en)
			vld_q[idx] <= 1'b1;
	end

	// lookup stage payload, checksum corrections added here
	always_ff @(posedge clk) begin
		if (rd_en) begin
			vld_s1  <= vld_q[idx];
			src_s1  <= head_cmd.src_addr;
			dst_s1  <= head_cmd.dst_addr;
			sum_s1  <= head_cmd.sum + SUM_W'(head_cmd.corr);
			ttl_s1  <= head_cmd.new_ttl;
			hb_s1   <= head_cmd.hdr_bytes;
			cnt_s1  <= head_cmd.count;
			cmpl_s1 <= head_cmd.complete;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= rd_en;
	end

	// match and checksum fold
	always_comb begin
		entry = vld_s1 ? rd_data_s1 : 64'd0;
		fold1 = 17'(sum_s1[SUM_W-1:16]) + 17'(sum_s1[15:0]);
		fold2 = fold1 + 17'(fold1[16]);
	end

	// result register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			forward      <= cmpl_s1 && (entry[63:32] == src_s1) && (entry[31:0] == dst_s1);
			new_ttl      <= ttl_s1;
			new_checksum <= ~fold2[15:0];
			header_bytes <= hb_s1;
			frame_length <= cnt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (s1_adv)
			result_valid <= 1'b1;
		else if (result_ready)
			result_valid <= 1'b0;
	end

endmodule
